// ===== design/ttl_key_value_cache_assert.svh =====
// Assertion macros for the cache RTL.
// Each expects clk and rst_n in scope of the module that uses it.
`ifndef TTL_KEY_VALUE_CACHE_ASSERT_SVH
`define TTL_KEY_VALUE_CACHE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TKVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ttl_kvc_pkg.sv =====
// Types and constants for the TTL key/value cache.
// No dependencies.
package ttl_kvc_pkg;

    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 64;
    localparam int LEN_W       = 4;
    localparam int FREE_W      = 7;
    localparam int STAMP_W     = 32;
    localparam int ACTION_W    = 2;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 80;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TTL         = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic [LEN_W-1:0]    length;
    } item_t;

    typedef struct packed {
        logic                ok;
        logic [VALUE_W-1:0]  value;
        logic [LEN_W-1:0]    length;
        logic [FREE_W-1:0]   free_count;
    } result_t;

endpackage

// ===== design/ttl_kvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttl_kvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ttl_kvc_front.sv =====
// Front end: takes input transactions, masks and clamps fields, queues them.
// Depends on ttl_kvc_pkg.
module ttl_kvc_front import ttl_kvc_pkg::*; #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [ACTION_W-1:0]  s_tuser,
    input  logic                 clearing,
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    localparam logic [KEY_W-1:0]   KEY_MASK   = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    item_t      in_item;
    logic [LEN_W-1:0] in_len;

    assign s_tready = !clearing && (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_len         = s_tdata[KEY_W+VALUE_W +: LEN_W];
        in_item.action = action_t'(s_tuser);
        in_item.key    = s_tdata[0 +: KEY_W] & KEY_MASK;
        in_item.value  = s_tdata[KEY_W +: VALUE_W] & VALUE_MASK;
        in_item.length = (in_len > MAX_LEN) ? MAX_LEN : in_len;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== design/ttl_kvc_engine.sv =====
// Back end: scans the entry RAM once per get, set or remove, sweeps, looks up, commits; a tick skips the scan.
// Depends on ttl_kvc_pkg, ttl_kvc_ram and the assertion macro header.
module ttl_kvc_engine import ttl_kvc_pkg::*; #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [FREE_W-1:0]   max_entries,
    input  logic [STAMP_W-1:0]  ttl_seconds,
    input  logic                q_valid,
    input  item_t               q_item,
    output logic                q_pop,
    output logic                clearing,
    output logic                m_valid,
    input  logic                m_ready,
    output result_t             m_result
);

    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int FW     = (CNT_W > FREE_W) ? CNT_W : FREE_W;
    localparam int KO     = 0;
    localparam int VO     = KEY_BITS;
    localparam int LO     = KEY_BITS + VALUE_BITS;
    localparam int SO     = LO + LEN_W;
    localparam int VLD    = SO + STAMP_W;
    localparam int EW     = VLD + 1;
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ENTRIES - 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_COMMIT = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    item_t               cur_reg, cur_next;
    logic                sweep_reg, sweep_next;
    logic                freed_reg, freed_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [EW-1:0]       hit_word_reg, hit_word_next;
    logic                free_found_reg, free_found_next;
    logic [ADDR_W-1:0]   free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [STAMP_W-1:0]  now_reg, now_next;
    logic                res_ok_reg, res_ok_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [LEN_W-1:0]    res_len_reg, res_len_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [EW-1:0]       ram_rdata;

    logic [KEY_BITS-1:0] cur_key;
    logic                rd_valid, expired, swept, eff_v, match;
    logic [EW-1:0]       set_word, get_word, rm_word, swept_word;
    logic [FW-1:0]       cap, held_w, free_now;

    ttl_kvc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign clearing = (state_reg == ST_CLEAR);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb
    begin
        cur_key  = cur_reg.key[KEY_BITS-1:0];
        rd_valid = ram_rdata[VLD];
        expired  = (now_reg - ram_rdata[SO +: STAMP_W]) > ttl_seconds;
        swept    = pend_reg && sweep_reg && rd_valid && expired;
        eff_v    = rd_valid && !swept;
        match    = eff_v && (ram_rdata[KO +: KEY_BITS] == cur_key);

        set_word = {1'b1, now_reg, cur_reg.length, cur_reg.value[VALUE_BITS-1:0], cur_key};
        get_word = hit_word_reg;
        get_word[SO +: STAMP_W] = now_reg;
        rm_word  = hit_word_reg;
        rm_word[VLD] = 1'b0;
        swept_word = ram_rdata;
        swept_word[VLD] = 1'b0;

        held_w   = FW'(held_reg);
        cap      = (FW'(max_entries) < FW'(ENTRIES)) ? FW'(max_entries) : FW'(ENTRIES);
        free_now = (cap > held_w) ? (cap - held_w) : '0;
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        cur_next        = cur_reg;
        sweep_next      = sweep_reg;
        freed_next      = freed_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_word_next   = hit_word_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        held_next       = held_reg;
        now_next        = now_reg;
        res_ok_next     = res_ok_reg;
        res_value_next  = res_value_reg;
        res_len_next    = res_len_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = scan_idx_reg;
        ram_wdata       = '0;
        q_pop           = 1'b0;

        // read data of the previous scan address
        if (pend_reg)
        begin
            if (swept)
            begin
                ram_we     = 1'b1;
                ram_waddr  = rd_idx_reg;
                ram_wdata  = swept_word;
                freed_next = 1'b1;
                held_next  = held_reg - CNT_W'(1);
            end
            if (match && !found_reg)
            begin
                found_next    = 1'b1;
                hit_idx_next  = rd_idx_reg;
                hit_word_next = ram_rdata;
            end
            if (!eff_v && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_idx_reg;
                ram_wdata = '0;
                if (scan_idx_reg == LAST)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.action == ACT_TICK)
                    begin
                        now_next       = now_reg + STAMP_W'(1);
                        res_ok_next    = 1'b0;
                        res_value_next = '0;
                        res_len_next   = '0;
                        state_next     = ST_RESULT;
                    end
                    else
                    begin
                        scan_idx_next   = '0;
                        sweep_next      = (q_item.action == ACT_SET) && (free_now == '0);
                        freed_next      = 1'b0;
                        found_next      = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next   = 1'b1;
                rd_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                res_ok_next    = 1'b0;
                res_value_next = '0;
                res_len_next   = '0;
                case (cur_reg.action)
                    ACT_SET:
                    begin
                        if (!sweep_reg || freed_reg)
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = found_reg ? hit_idx_reg : free_idx_reg;
                            ram_wdata   = set_word;
                            res_ok_next = 1'b1;
                            if (!found_reg)
                            begin
                                held_next = held_reg + CNT_W'(1);
                            end
                        end
                    end
                    ACT_GET:
                    begin
                        if (found_reg)
                        begin
                            ram_we         = 1'b1;
                            ram_waddr      = hit_idx_reg;
                            ram_wdata      = get_word;
                            res_ok_next    = 1'b1;
                            res_value_next = VALUE_W'(hit_word_reg[VO +: VALUE_BITS]);
                            res_len_next   = hit_word_reg[LO +: LEN_W];
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_idx_reg;
                            ram_wdata = rm_word;
                            held_next = held_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.ok         = res_ok_reg;
                    out_next.value      = res_value_reg;
                    out_next.length     = res_len_reg;
                    out_next.free_count = free_now[FREE_W-1:0];
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        cur_reg        <= cur_next;
        hit_idx_reg    <= hit_idx_next;
        hit_word_reg   <= hit_word_next;
        free_idx_reg   <= free_idx_next;
        res_ok_reg     <= res_ok_next;
        res_value_reg  <= res_value_next;
        res_len_reg    <= res_len_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            sweep_reg      <= 1'b0;
            freed_reg      <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            held_reg       <= '0;
            now_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            sweep_reg      <= sweep_next;
            freed_reg      <= freed_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            held_reg       <= held_next;
            now_reg        <= now_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`include "ttl_key_value_cache_assert.svh"

    `TKVC_ASSERT_NOW(a_held_range, 1'b1, held_reg <= CNT_W'(ENTRIES), "held count above table size")
    `TKVC_ASSERT_NOW(a_no_pop_clear, state_reg == ST_CLEAR, !q_pop, "queue popped during clear")
    `TKVC_ASSERT_NEXT(a_commit_result, state_reg == ST_COMMIT, state_reg == ST_RESULT, "commit not followed by result")
    `TKVC_ASSERT_NOW(a_no_overwrite, out_valid_reg && !m_ready, !$stable(state_reg) || state_reg != ST_IDLE || out_valid_next, "pending result dropped")

endmodule

// ===== design/ttl_key_value_cache.sv =====
// TTL key/value cache. Each transaction is queued by the front end and then
// executed by a back end that walks the entry RAM one entry per cycle for a
// get, set or remove (the RAM scan, with expiry sweep folded into the same
// pass for a set on a full table); a tick skips the scan. After reset the
// entry RAM is cleared, and while it is, s_tready stays low; configuration
// writes are taken at any time.
// Depends on ttl_kvc_pkg, ttl_kvc_front, ttl_kvc_engine, ttl_kvc_ram.
module ttl_key_value_cache import ttl_kvc_pkg::*; #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // key, value_in, length_in, zero pad
    input  logic [ACTION_W-1:0]    s_tuser,   // action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // value_out, length_out, free_count, zero pad
    output logic [0:0]             m_tuser,   // ok
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [FREE_W-1:0]  max_entries_reg;
    logic [STAMP_W-1:0] ttl_reg;
    logic               clearing;
    logic               q_valid, q_pop;
    item_t              q_item;
    result_t            result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= 7'd64;
            ttl_reg         <= 32'd60;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_data[FREE_W-1:0];
                CFG_TTL:         ttl_reg         <= cfg_data[STAMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ttl_kvc_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ttl_kvc_engine #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_entries (max_entries_reg),
        .ttl_seconds (ttl_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result)
    );

    assign m_tdata = {5'd0, result.free_count, result.length, result.value};
    assign m_tuser = result.ok;

endmodule
